// ===== hw/rtl/smh_pkg.sv =====
// Shared types, codes and widths for the sieve min-heap block.
package smh_pkg;

   localparam int unsigned DEFAULT_CAPACITY = 1024;
   localparam int unsigned PRIME_W = 32;
   localparam int unsigned MULT_W = 64;
   localparam int unsigned COUNT_OUT_W = 11;
   localparam int unsigned STATUS_W = 2;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_ADVANCE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd3;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      logic [PRIME_W-1:0] prime;
      logic [MULT_W-1:0] mult;
   } entry_type;

endpackage

// ===== hw/rtl/smh_mem.sv =====
// Heap storage: one write port and two registered read ports.
module smh_mem import smh_pkg::*; #(
   parameter int unsigned DEPTH = DEFAULT_CAPACITY,
   localparam int unsigned AddrW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  entry_type        wr_data,
   input  logic [AddrW-1:0] rd_addr0,
   input  logic [AddrW-1:0] rd_addr1,
   output entry_type        rd_data0,
   output entry_type        rd_data1
);

   entry_type store [DEPTH];
   entry_type rd_data0_ff;
   entry_type rd_data1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[wr_addr] <= wr_data;
      end
      rd_data0_ff <= store[rd_addr0];
      rd_data1_ff <= store[rd_addr1];
   end

   assign rd_data0 = rd_data0_ff;
   assign rd_data1 = rd_data1_ff;

endmodule

// ===== hw/rtl/smh_alu.sv =====
// Shared 64-bit adder that serves both the multiple step and every key compare.
module smh_alu import smh_pkg::*; (
   input  logic [MULT_W-1:0] a,
   input  logic [MULT_W-1:0] b,
   input  alu_op_type        op,
   output logic [MULT_W-1:0] result,
   output logic              carry,
   output logic              lt
);

   logic [MULT_W-1:0] b_eff;
   logic              carry_in;
   logic [MULT_W:0]   total;

   always_comb begin
      unique case (op)
         ALU_ADD: begin
            b_eff = b;
            carry_in = 1'b0;
         end
         ALU_SUB: begin
            b_eff = ~b;
            carry_in = 1'b1;
         end
         default: begin
            b_eff = b;
            carry_in = 1'b0;
         end
      endcase
   end

   assign total = {1'b0, a} + {1'b0, b_eff} + {{MULT_W{1'b0}}, carry_in};
   assign result = total[MULT_W-1:0];
   assign carry = total[MULT_W];
   // A subtract without carry out means a borrow, so a is below b.
   assign lt = (op == ALU_SUB) && !total[MULT_W];

endmodule

// ===== hw/rtl/sieve_min_heap_top.sv =====
// Top level of the sieve min-heap: sequencer, head copy and response register.
//
//   channel | direction | ports                                   | handshake
//   req     | in        | req_func, req_prime                     | req_valid / req_stall
//   rsp     | out       | rsp_status, rsp_head_multiple,          | rsp_valid / rsp_stall
//           |           | rsp_head_prime, rsp_entry_count         |
//
// An insert squares the prime in ST_MUL, then climbs through ST_UP_RD and ST_UP_CMP,
// one memory read and one adder compare per level; an advance adds in ST_ADD, then
// descends through ST_DN_RD, ST_DN_PICK and ST_DN_CMP. Full and empty cases go straight to
// ST_DONE, overflow from ST_ADD; ST_DONE returns to ST_IDLE for the next request.
// Reset clears the entry count; the storage itself needs no clearing.
// req_stall is high while an item is in work; a stalled response waits in its register.
module sieve_min_heap_top import smh_pkg::*; #(
   parameter int unsigned CAPACITY = DEFAULT_CAPACITY
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_func,
   input  logic [PRIME_W-1:0]     req_prime,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [MULT_W-1:0]      rsp_head_multiple,
   output logic [PRIME_W-1:0]     rsp_head_prime,
   output logic [COUNT_OUT_W-1:0] rsp_entry_count
);

   localparam int unsigned AW = $clog2(CAPACITY);
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned IW = AW + 2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_UP_RD,
      ST_UP_CMP,
      ST_ADD,
      ST_DN_RD,
      ST_DN_PICK,
      ST_DN_CMP,
      ST_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     hole_ff, hole_in;
   entry_type         x_ff, x_in;
   entry_type         pick_ff, pick_in;
   logic [AW-1:0]     pick_idx_ff, pick_idx_in;
   logic              right_ok_ff, right_ok_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   entry_type         head_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [MULT_W-1:0]      rsp_head_multiple_ff, rsp_head_multiple_in;
   logic [PRIME_W-1:0]     rsp_head_prime_ff, rsp_head_prime_in;
   logic [COUNT_OUT_W-1:0] rsp_entry_count_ff, rsp_entry_count_in;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   entry_type         wr_data;
   logic [AW-1:0]     rd_addr0, rd_addr1;
   entry_type         rd_data0, rd_data1;

   logic [MULT_W-1:0] alu_a, alu_b, alu_result;
   alu_op_type        alu_op;
   logic              alu_carry, alu_lt;

   logic [MULT_W-1:0] square;
   logic [AW-1:0]     parent_idx;
   logic [IW-1:0]     left_idx, right_idx;
   logic              req_fire;

   smh_mem #(.DEPTH(CAPACITY)) u_mem (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr0 (rd_addr0),
      .rd_addr1 (rd_addr1),
      .rd_data0 (rd_data0),
      .rd_data1 (rd_data1)
   );

   smh_alu u_alu (
      .a      (alu_a),
      .b      (alu_b),
      .op     (alu_op),
      .result (alu_result),
      .carry  (alu_carry),
      .lt     (alu_lt)
   );

   assign square = x_ff.prime * x_ff.prime;
   assign parent_idx = (hole_ff - AW'(1)) >> 1;
   assign left_idx = {1'b0, hole_ff, 1'b1};
   assign right_idx = left_idx + IW'(1);

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      hole_in = hole_ff;
      x_in = x_ff;
      pick_in = pick_ff;
      pick_idx_in = pick_idx_ff;
      right_ok_in = right_ok_ff;
      status_in = status_ff;
      wr_en = 1'b0;
      wr_addr = hole_ff;
      wr_data = x_ff;
      rd_addr0 = hole_ff;
      rd_addr1 = hole_ff;
      alu_a = x_ff.mult;
      alu_b = rd_data0.mult;
      alu_op = ALU_SUB;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_head_multiple_in = rsp_head_multiple_ff;
      rsp_head_prime_in = rsp_head_prime_ff;
      rsp_entry_count_in = rsp_entry_count_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               status_in = STATUS_OK;
               if (req_func == FUNC_INSERT) begin
                  if (count_ff == CW'(CAPACITY)) begin
                     status_in = STATUS_FULL;
                     state_in = ST_DONE;
                  end else begin
                     x_in.prime = req_prime;
                     hole_in = AW'(count_ff);
                     count_in = count_ff + CW'(1);
                     state_in = ST_MUL;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_ADD;
                  end
               end
            end
         end
         ST_MUL: begin
            x_in.mult = square;
            state_in = ST_UP_RD;
         end
         ST_UP_RD: begin
            if (hole_ff == '0) begin
               wr_en = 1'b1;
               state_in = ST_DONE;
            end else begin
               rd_addr0 = parent_idx;
               state_in = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            // The new entry climbs only while strictly below its parent.
            if (alu_lt) begin
               wr_en = 1'b1;
               wr_data = rd_data0;
               hole_in = parent_idx;
               state_in = ST_UP_RD;
            end else begin
               wr_en = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_ADD: begin
            alu_a = head_ff.mult;
            alu_b = {{(MULT_W - PRIME_W - 1){1'b0}}, head_ff.prime, 1'b0};
            alu_op = ALU_ADD;
            if (alu_carry) begin
               status_in = STATUS_OVERFLOW;
               state_in = ST_DONE;
            end else begin
               x_in.prime = head_ff.prime;
               x_in.mult = alu_result;
               hole_in = '0;
               state_in = ST_DN_RD;
            end
         end
         ST_DN_RD: begin
            if (left_idx >= IW'(count_ff)) begin
               wr_en = 1'b1;
               state_in = ST_DONE;
            end else begin
               right_ok_in = right_idx < IW'(count_ff);
               rd_addr0 = left_idx[AW-1:0];
               rd_addr1 = right_ok_in ? right_idx[AW-1:0] : left_idx[AW-1:0];
               state_in = ST_DN_PICK;
            end
         end
         ST_DN_PICK: begin
            alu_a = rd_data0.mult;
            alu_b = rd_data1.mult;
            // On equal keys the right child wins.
            if (right_ok_ff && !alu_lt) begin
               pick_in = rd_data1;
               pick_idx_in = right_idx[AW-1:0];
            end else begin
               pick_in = rd_data0;
               pick_idx_in = left_idx[AW-1:0];
            end
            state_in = ST_DN_CMP;
         end
         ST_DN_CMP: begin
            alu_a = pick_ff.mult;
            alu_b = x_ff.mult;
            if (alu_lt) begin
               wr_en = 1'b1;
               wr_data = pick_ff;
               hole_in = pick_idx_ff;
               state_in = ST_DN_RD;
            end else begin
               wr_en = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = status_ff;
               rsp_head_multiple_in = (count_ff == '0) ? '0 : head_ff.mult;
               rsp_head_prime_in = (count_ff == '0) ? '0 : head_ff.prime;
               rsp_entry_count_in = COUNT_OUT_W'(count_ff);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hole_ff <= hole_in;
      x_ff <= x_in;
      pick_ff <= pick_in;
      pick_idx_ff <= pick_idx_in;
      right_ok_ff <= right_ok_in;
      status_ff <= status_in;
      // Slot zero is mirrored so the head is on hand without a memory read.
      if (wr_en && wr_addr == '0) begin
         head_ff <= wr_data;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_head_multiple_ff <= rsp_head_multiple_in;
      rsp_head_prime_ff <= rsp_head_prime_in;
      rsp_entry_count_ff <= rsp_entry_count_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_head_multiple = rsp_head_multiple_ff;
   assign rsp_head_prime = rsp_head_prime_ff;
   assign rsp_entry_count = rsp_entry_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_func == FUNC_INSERT && count_ff != CW'(CAPACITY)
      |=> count_ff == $past(count_ff) + CW'(1))
      else $error("accepted insert did not grow the heap");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> CW'(wr_addr) < count_ff)
      else $error("heap write beyond the entry count");

   a_hole_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UP_RD || state_ff == ST_UP_CMP || state_ff == ST_DN_RD ||
       state_ff == ST_DN_PICK || state_ff == ST_DN_CMP)
      |-> CW'(hole_ff) < count_ff)
      else $error("sift position beyond the entry count");

   a_advance_keeps_count: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_func == FUNC_ADVANCE |=> count_ff == $past(count_ff))
      else $error("advance changed the entry count");

endmodule
